// ===== rtl/core/ptss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_pkg
// Shared codes and types for the periodic task slot scheduler.
// ----------------------------------------------------------------------------
package ptss_pkg;

    // command codes
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ADD    = 3'd1;
    localparam logic [2:0] MODE_REMOVE = 3'd2;
    localparam logic [2:0] MODE_QUERY  = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;
    localparam logic [2:0] MODE_MARK   = 3'd5;

    // event codes
    localparam logic [1:0] EV_ACK     = 2'd0;
    localparam logic [1:0] EV_FIRE    = 2'd1;
    localparam logic [1:0] EV_REMOVED = 2'd2;

    // one stored slot, valid bit kept apart in flops
    typedef struct packed {
        logic [7:0]  task_id;
        logic [3:0]  task_type;
        logic [15:0] interval;
        logic [15:0] elapsed;
        logic        done;
    } slot_rec_t;

    // one queued tick event
    typedef struct packed {
        logic [1:0] res;
        logic [7:0] task_id;
    } ev_t;

    // what the slot unit wants done with the slot it looked at
    typedef struct packed {
        logic      wr_en;
        slot_rec_t wr_rec;
        logic      set_valid;
        logic      clr_valid;
        logic      hit;
        logic      id_seen;
        logic      type_seen;
        logic      push;
        ev_t       ev;
    } slot_act_t;

endpackage
`default_nettype wire

// ===== rtl/core/ptss_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_in_if
// Command channel: valid/ready plus one command item.
// ----------------------------------------------------------------------------
interface ptss_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  task_id;
    logic [3:0]  task_type;
    logic [15:0] interval;

    modport source (output valid, output mode, output task_id, output task_type,
                    output interval, input ready);
    modport sink (input valid, input mode, input task_id, input task_type,
                  input interval, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ptss_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_out_if
// Result channel: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface ptss_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] event_task_id;
    logic       last;
    logic       id_present;
    logic       type_present;
    logic       table_full;
    logic [3:0] task_count;

    modport source (output valid, output event_res, output event_task_id,
                    output last, output id_present, output type_present,
                    output table_full, output task_count, input ready);
    modport sink (input valid, input event_res, input event_task_id,
                  input last, input id_present, input type_present,
                  input table_full, input task_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ptss_slot_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_slot_mem
// Slot record store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptss_slot_mem #(
    parameter int SLOTS = 8,
    parameter int IW    = 3
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [IW-1:0]        wr_addr,
    input  wire ptss_pkg::slot_rec_t  wr_data,
    input  wire logic                 rd_en,
    input  wire logic [IW-1:0]        rd_addr,
    output ptss_pkg::slot_rec_t       rd_data
);

    ptss_pkg::slot_rec_t mem [SLOTS];
    ptss_pkg::slot_rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ptss_evq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_evq
// Event queue for one tick: filled during the walk, drained afterwards.
// ----------------------------------------------------------------------------
module ptss_evq #(
    parameter int SLOTS = 8,
    parameter int IW    = 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          clr,
    input  wire logic          push,
    input  wire ptss_pkg::ev_t push_data,
    input  wire logic          pop,
    output ptss_pkg::ev_t      rd_data,
    output logic               rd_last,
    output logic               empty
);

    ptss_pkg::ev_t mem [SLOTS];
    ptss_pkg::ev_t rd_data_reg;
    logic          rd_last_reg;
    logic [IW:0]   wr_ptr_reg;
    logic [IW:0]   rd_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else if (clr)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + (IW+1)'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + (IW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg[IW-1:0]] <= push_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg[IW-1:0]];
            rd_last_reg <= ((rd_ptr_reg + (IW+1)'(1)) == wr_ptr_reg);
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_last = rd_last_reg;
    assign empty   = (rd_ptr_reg == wr_ptr_reg);

endmodule
`default_nettype wire

// ===== rtl/core/ptss_slot_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptss_slot_unit
// Shared compare/update unit: decides what one command does to one slot.
// ----------------------------------------------------------------------------
module ptss_slot_unit (
    input  wire logic [2:0]          mode,
    input  wire logic                valid,
    input  wire logic                hit,
    input  wire ptss_pkg::slot_rec_t rec,
    input  wire logic [7:0]          task_id,
    input  wire logic [3:0]          task_type,
    input  wire logic [15:0]         interval,
    output ptss_pkg::slot_act_t      act
);

    logic id_eq;
    logic type_eq;
    logic below;

    assign id_eq   = (rec.task_id == task_id);
    assign type_eq = (rec.task_type == task_type);
    assign below   = (rec.elapsed < rec.interval);

    always_comb
    begin
        act            = '0;
        act.wr_rec     = rec;
        act.ev.task_id = rec.task_id;
        act.ev.res     = ptss_pkg::EV_ACK;
        unique case (mode)
            ptss_pkg::MODE_TICK:
            begin
                if (valid)
                begin
                    if (rec.done)
                    begin
                        act.clr_valid = 1'b1;
                        act.push      = 1'b1;
                        act.ev.res    = ptss_pkg::EV_REMOVED;
                    end
                    else if (below)
                    begin
                        act.wr_en          = 1'b1;
                        act.wr_rec.elapsed = rec.elapsed + 16'd1;
                    end
                    else
                    begin
                        act.wr_en          = 1'b1;
                        act.wr_rec.elapsed = '0;
                        act.push           = 1'b1;
                        act.ev.res         = ptss_pkg::EV_FIRE;
                    end
                end
            end
            ptss_pkg::MODE_ADD:
            begin
                if (!valid && !hit)
                begin
                    act.wr_en            = 1'b1;
                    act.wr_rec.task_id   = task_id;
                    act.wr_rec.task_type = task_type;
                    act.wr_rec.interval  = interval;
                    act.wr_rec.elapsed   = interval;
                    act.wr_rec.done      = 1'b0;
                    act.set_valid        = 1'b1;
                    act.hit              = 1'b1;
                end
            end
            ptss_pkg::MODE_REMOVE:
            begin
                if (valid && !hit && id_eq)
                begin
                    act.clr_valid = 1'b1;
                    act.hit       = 1'b1;
                end
            end
            ptss_pkg::MODE_QUERY:
            begin
                act.id_seen   = valid && id_eq;
                act.type_seen = valid && type_eq;
            end
            ptss_pkg::MODE_MARK:
            begin
                if (valid && id_eq)
                begin
                    act.wr_en       = 1'b1;
                    act.wr_rec.done = 1'b1;
                end
            end
            default:
            begin
                act.wr_en = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/periodic_task_slot_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler
// Table of SLOTS periodic task slots driven by tick/add/remove/query/clear/
// mark-complete commands.
// ----------------------------------------------------------------------------
// The block takes one command item on req and answers on rsp; it accepts
// no new command until the last result item (last = 1) of the current one
// has been taken. Tick, add, remove, query and mark-complete walk the slot
// table in index order through one shared slot unit: a read state and an
// execute state per slot visited (the slot record store has a registered
// read port), then a done state. Add and remove stop at the slot they act
// on. A tick queues its fired/removed events during the walk and then
// drains them through a fetch and a load state per event plus the rsp
// handshake, so every event item carries the task count after the whole
// tick. Clear and the unused codes answer in the cycle after accept.
// Valid bits and the task count reset to zero; slot records are only used
// in valid slots and need no clearing.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler #(
    parameter int SLOTS = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ptss_in_if.sink   req,
    ptss_out_if.source rsp
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_DONE  = 6'b001000,
        ST_FETCH = 6'b010000,
        ST_LOAD  = 6'b100000
    } state_t;

    // ST_SEND is folded into its own one-hot flop below
    state_t state_reg, state_next;
    logic   send_reg, send_next;

    // latched command
    logic [2:0]  mode_reg;
    logic [7:0]  id_reg;
    logic [3:0]  type_reg;
    logic [15:0] ivl_reg;

    // table control state
    logic [SLOTS-1:0] valid_reg;
    logic [CW-1:0]    count_reg;
    logic [IW-1:0]    idx_reg;
    logic             hit_reg;
    logic             idp_reg;
    logic             tp_reg;

    // result register
    logic [1:0] o_res_reg;
    logic [7:0] o_id_reg;
    logic       o_last_reg;
    logic       o_idp_reg;
    logic       o_tp_reg;
    logic       o_full_reg;
    logic [3:0] o_count_reg;

    ptss_pkg::slot_rec_t rd_rec;
    ptss_pkg::slot_act_t act;
    ptss_pkg::ev_t       ev_data;
    logic                ev_last;
    logic                ev_empty;
    logic                accept;
    logic                exec;
    logic                at_end;
    logic                is_tick;
    logic [CW+3:0]       count_ext;

    assign accept    = req.valid && req.ready;
    assign exec      = (state_reg == ST_EXEC);
    assign at_end    = (idx_reg == IW'(SLOTS - 1));
    assign is_tick   = (mode_reg == ptss_pkg::MODE_TICK);
    assign count_ext = {4'b0000, count_reg};

    ptss_slot_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
        .clk     (clk),
        .we      (exec && act.wr_en),
        .wr_addr (idx_reg),
        .wr_data (act.wr_rec),
        .rd_en   (state_reg == ST_READ),
        .rd_addr (idx_reg),
        .rd_data (rd_rec)
    );

    ptss_slot_unit u_unit (
        .mode      (mode_reg),
        .valid     (valid_reg[idx_reg]),
        .hit       (hit_reg),
        .rec       (rd_rec),
        .task_id   (id_reg),
        .task_type (type_reg),
        .interval  (ivl_reg),
        .act       (act)
    );

    ptss_evq #(.SLOTS(SLOTS), .IW(IW)) u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (accept),
        .push      (exec && act.push),
        .push_data (act.ev),
        .pop       (state_reg == ST_FETCH),
        .rd_data   (ev_data),
        .rd_last   (ev_last),
        .empty     (ev_empty)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        send_next  = send_reg;
        if (send_reg)
        begin
            if (rsp.ready)
            begin
                send_next = 1'b0;
                if (is_tick && !ev_empty)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        unique case (req.mode) inside
                            ptss_pkg::MODE_TICK, ptss_pkg::MODE_ADD,
                            ptss_pkg::MODE_REMOVE, ptss_pkg::MODE_QUERY,
                            ptss_pkg::MODE_MARK:
                            begin
                                state_next = ST_READ;
                            end
                            default:
                            begin
                                send_next = 1'b1;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    state_next = ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (at_end || act.hit)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
                ST_DONE:
                begin
                    if (is_tick && !ev_empty)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        send_next = 1'b1;
                    end
                end
                ST_FETCH:
                begin
                    state_next = ST_LOAD;
                end
                ST_LOAD:
                begin
                    send_next = 1'b1;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            send_reg  <= 1'b0;
            valid_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            idp_reg   <= 1'b0;
            tp_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            send_reg  <= send_next;
            if (accept)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
                idp_reg <= 1'b0;
                tp_reg  <= 1'b0;
                if (req.mode == ptss_pkg::MODE_CLEAR)
                begin
                    valid_reg <= '0;
                    count_reg <= '0;
                end
            end
            else if (exec)
            begin
                if (act.set_valid)
                begin
                    valid_reg[idx_reg] <= 1'b1;
                    count_reg          <= count_reg + CW'(1);
                end
                else if (act.clr_valid)
                begin
                    valid_reg[idx_reg] <= 1'b0;
                    count_reg          <= count_reg - CW'(1);
                end
                hit_reg <= hit_reg || act.hit;
                idp_reg <= idp_reg || act.id_seen;
                tp_reg  <= tp_reg || act.type_seen;
                if (!at_end)
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
        end
    end

    // command latch and result register (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= req.mode;
            id_reg      <= req.task_id;
            type_reg    <= req.task_type;
            ivl_reg     <= req.interval;
            // clear and unused codes answer straight away
            o_res_reg   <= ptss_pkg::EV_ACK;
            o_id_reg    <= '0;
            o_last_reg  <= 1'b1;
            o_idp_reg   <= 1'b0;
            o_tp_reg    <= 1'b0;
            o_full_reg  <= 1'b0;
            o_count_reg <= (req.mode == ptss_pkg::MODE_CLEAR) ? 4'd0 : count_ext[3:0];
        end
        else if (state_reg == ST_DONE && !send_reg)
        begin
            o_res_reg   <= ptss_pkg::EV_ACK;
            o_id_reg    <= '0;
            o_last_reg  <= 1'b1;
            o_idp_reg   <= idp_reg;
            o_tp_reg    <= tp_reg;
            o_full_reg  <= (mode_reg == ptss_pkg::MODE_ADD) && !hit_reg;
            o_count_reg <= count_ext[3:0];
        end
        else if (state_reg == ST_LOAD && !send_reg)
        begin
            o_res_reg   <= ev_data.res;
            o_id_reg    <= ev_data.task_id;
            o_last_reg  <= ev_last;
            o_idp_reg   <= 1'b0;
            o_tp_reg    <= 1'b0;
            o_full_reg  <= 1'b0;
            o_count_reg <= count_ext[3:0];
        end
    end

    assign req.ready         = (state_reg == ST_IDLE) && !send_reg;
    assign rsp.valid         = send_reg;
    assign rsp.event_res     = o_res_reg;
    assign rsp.event_task_id = o_id_reg;
    assign rsp.last          = o_last_reg;
    assign rsp.id_present    = o_idp_reg;
    assign rsp.type_present  = o_tp_reg;
    assign rsp.table_full    = o_full_reg;
    assign rsp.task_count    = o_count_reg;

    // the two sides never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rsp.valid && req.ready))
        else $error("command accepted while a result is pending");

    // count tracks the valid bits whenever the block is idle
    a_count_sync: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> ($countones(valid_reg) == 32'(count_reg)))
        else $error("task count out of step with valid bits");

    // the final result returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && rsp.last) |=> req.ready)
        else $error("block not idle after final result");

    // a result that is not the final one is always a tick event
    a_mid_event: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |->
            (rsp.event_res == ptss_pkg::EV_FIRE || rsp.event_res == ptss_pkg::EV_REMOVED))
        else $error("non-final result without an event");

endmodule
`default_nettype wire
